### rtl/sfd_pkg.sv
// ----------------------------------------------------------------------------
// sfd_pkg: shared definitions for the SBUS frame decoder
// Frame layout constants, the queued frame record and the queue status.
// ----------------------------------------------------------------------------
package sfd_pkg;

    localparam int WIN_DEPTH   = 24;   // window bytes kept in registers (0..23)
    localparam int HELD_W      = 5;    // width of the held-byte count (0..24)
    localparam int DATA_BYTES  = 22;   // channel payload, frame bytes 1..22
    localparam int FLAGS_POS   = 23;   // flags byte position in the frame
    localparam int DATA_W      = DATA_BYTES * 8;
    localparam int CHAN_BITS   = 11;
    localparam int CHAN_W      = 4;
    localparam int ERR_W       = 16;

    localparam logic [HELD_W-1:0] HELD_FULL  = HELD_W'(WIN_DEPTH);
    localparam logic [CHAN_W-1:0] CHAN_FIRST = '0;
    localparam logic [CHAN_W-1:0] CHAN_LAST  = '1;
    localparam logic [ERR_W-1:0]  ERR_MAX    = '1;

    localparam logic [7:0] START_BYTE = 8'h0f;
    localparam logic [7:0] END_BYTE_0 = 8'h04;
    localparam logic [7:0] END_BYTE_1 = 8'h14;
    localparam logic [7:0] END_BYTE_2 = 8'h24;
    localparam logic [7:0] END_BYTE_3 = 8'h34;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = Q_PTR_W + 1;

    typedef struct packed {
        logic [DATA_W-1:0] bits;    // frame bytes 1..22, byte 1 in the low bits
        logic [7:0]        flags;
        logic [ERR_W-1:0]  err;
    } t_frame;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic logic f_end_ok(input logic [7:0] b);
        return b inside {END_BYTE_0, END_BYTE_1, END_BYTE_2, END_BYTE_3};
    endfunction

endpackage

### rtl/sfd_front.sv
// ----------------------------------------------------------------------------
// sfd_front: byte window and frame classification
// Collects bytes, checks start and end bytes and forwards good frames.
// ----------------------------------------------------------------------------
module sfd_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic [7:0]                  i_rx_byte,
    output logic                        o_push,
    output sfd_pkg::t_frame             o_frame
);

    logic [7:0]                   r_win [sfd_pkg::WIN_DEPTH];
    logic [7:0]                   n_win [sfd_pkg::WIN_DEPTH];
    logic [sfd_pkg::HELD_W-1:0]   r_held, n_held;
    logic [sfd_pkg::ERR_W-1:0]    r_err, n_err;
    logic                         full_now;
    logic                         start_ok;
    logic                         end_ok;

    assign full_now = (r_held == sfd_pkg::HELD_FULL);
    assign start_ok = (r_win[0] == sfd_pkg::START_BYTE);
    assign end_ok   = sfd_pkg::f_end_ok(i_rx_byte);
    assign o_push   = i_accept && full_now && start_ok && end_ok;

    always_comb begin
        for (int j = 0; j < sfd_pkg::DATA_BYTES; j++) begin
            o_frame.bits[j*8 +: 8] = r_win[j+1];
        end
        o_frame.flags = r_win[sfd_pkg::FLAGS_POS];
        o_frame.err   = r_err;
    end

    always_comb begin
        n_win  = r_win;
        n_held = r_held;
        n_err  = r_err;
        if (i_accept) begin
            if (!full_now) begin
                for (int i = 0; i < sfd_pkg::WIN_DEPTH; i++) begin
                    if (r_held == sfd_pkg::HELD_W'(i)) begin
                        n_win[i] = i_rx_byte;
                    end
                end
                n_held = r_held + 1'b1;
            end else if (start_ok && end_ok) begin
                n_held = '0;
            end else begin
                // Drop the first byte; the new byte lands at the top.
                for (int i = 0; i < sfd_pkg::WIN_DEPTH - 1; i++) begin
                    n_win[i] = r_win[i+1];
                end
                n_win[sfd_pkg::WIN_DEPTH-1] = i_rx_byte;
                if (start_ok && r_err != sfd_pkg::ERR_MAX) begin
                    n_err = r_err + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_win <= n_win;
        if (!i_rst_n) begin
            r_held <= '0;
            r_err  <= '0;
        end else begin
            r_held <= n_held;
            r_err  <= n_err;
        end
    end

endmodule

### rtl/sfd_queue.sv
// ----------------------------------------------------------------------------
// sfd_queue: short frame queue
// Holds decoded-ready frames between the classifier and the channel emitter.
// ----------------------------------------------------------------------------
module sfd_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  sfd_pkg::t_frame      i_frame,
    input  logic                 i_pop,
    output sfd_pkg::t_frame      o_frame,
    output sfd_pkg::t_q_stat     o_stat
);

    sfd_pkg::t_frame               r_mem [sfd_pkg::Q_DEPTH];
    logic [sfd_pkg::Q_PTR_W-1:0]   r_wr, r_rd;
    logic [sfd_pkg::Q_CNT_W-1:0]   r_cnt, n_cnt;

    assign o_stat.full  = (r_cnt == sfd_pkg::Q_CNT_W'(sfd_pkg::Q_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_frame      = r_mem[r_rd];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_frame;
        end
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= n_cnt;
        end
    end

endmodule

### rtl/sfd_back.sv
// ----------------------------------------------------------------------------
// sfd_back: channel emitter
// Unpacks one queued frame into sixteen channel requests, one per cycle unless stalled.
// ----------------------------------------------------------------------------
module sfd_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  sfd_pkg::t_frame              i_frame,
    input  sfd_pkg::t_q_stat             i_stat,
    output logic                         o_pop,
    input  logic                         i_stall,
    output logic                         o_valid,
    output logic [sfd_pkg::CHAN_W-1:0]   o_channel_index,
    output logic [sfd_pkg::CHAN_BITS-1:0] o_channel_value,
    output logic [7:0]                   o_frame_flags,
    output logic [sfd_pkg::ERR_W-1:0]    o_error_total,
    output logic                         o_last_of_frame
);

    logic                          r_busy, n_busy;
    logic [sfd_pkg::CHAN_W-1:0]    r_chan, n_chan;
    logic [sfd_pkg::DATA_W-1:0]    r_bits, n_bits;
    logic [7:0]                    r_flags, n_flags;
    logic [sfd_pkg::ERR_W-1:0]     r_err, n_err;
    logic                          out_take;
    logic                          is_last;

    assign is_last  = (r_chan == sfd_pkg::CHAN_LAST);
    assign out_take = r_busy && !i_stall;
    assign o_pop    = !i_stat.empty && (!r_busy || (out_take && is_last));

    assign o_valid         = r_busy;
    assign o_channel_index = r_chan;
    assign o_channel_value = r_bits[sfd_pkg::CHAN_BITS-1:0];
    assign o_frame_flags   = r_flags;
    assign o_error_total   = r_err;
    assign o_last_of_frame = is_last;

    always_comb begin
        n_busy  = r_busy;
        n_chan  = r_chan;
        n_bits  = r_bits;
        n_flags = r_flags;
        n_err   = r_err;
        if (o_pop) begin
            n_busy  = 1'b1;
            n_chan  = sfd_pkg::CHAN_FIRST;
            n_bits  = i_frame.bits;
            n_flags = i_frame.flags;
            n_err   = i_frame.err;
        end else if (out_take) begin
            if (is_last) begin
                n_busy = 1'b0;
            end else begin
                n_chan = r_chan + 1'b1;
                n_bits = r_bits >> sfd_pkg::CHAN_BITS;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_chan  <= n_chan;
        r_bits  <= n_bits;
        r_flags <= n_flags;
        r_err   <= n_err;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
    end

endmodule

### rtl/sbus_frame_decoder_unit.sv
// ----------------------------------------------------------------------------
// sbus_frame_decoder_unit: SBUS frame decoder, sixteen 11-bit channels
// Byte window with start/end checks, a frame queue and a channel emitter.
// ----------------------------------------------------------------------------
// Throughput: one byte request per cycle in while the frame queue is not
// full, and one channel request per cycle out while the output is not
// stalled; the input stalls only while the two-entry frame queue is full.
// The byte that completes a frame is written into the frame queue, and an
// idle emitter then loads it into its registers and presents channel 0.
// Reset is synchronous and active low; it clears window, queue, emitter, count.
module sbus_frame_decoder_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [7:0]                    i_rx_byte,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [sfd_pkg::CHAN_W-1:0]    o_channel_index,
    output logic [sfd_pkg::CHAN_BITS-1:0] o_channel_value,
    output logic [7:0]                    o_frame_flags,
    output logic [sfd_pkg::ERR_W-1:0]     o_error_total,
    output logic                          o_last_of_frame
);

    // Queue status shared by the front stall and the emitter's pop.
    sfd_pkg::t_q_stat  q_stat;
    sfd_pkg::t_frame   push_frame;
    sfd_pkg::t_frame   pop_frame;
    logic              push;
    logic              pop;
    logic              in_take;

    // The front never needs to wait on the emitter directly: a full queue is
    // the only backpressure, so the stall is simply the queue's full flag.
    assign o_stall = q_stat.full;
    assign in_take = i_valid && !q_stat.full;

    // The front keeps the byte window and the bad-end counter. A byte that
    // completes a good frame pushes the channel payload, flags and the
    // current error count into the queue in the same cycle.
    sfd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (in_take),
        .i_rx_byte (i_rx_byte),
        .o_push    (push),
        .o_frame   (push_frame)
    );

    // Two frames of slack let the window keep filling while the emitter
    // drains a frame and the output side is stalled.
    sfd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_frame (push_frame),
        .i_pop   (pop),
        .o_frame (pop_frame),
        .o_stat  (q_stat)
    );

    // The emitter shifts the 176-bit payload down by eleven bits per taken
    // request, so each channel is always the low bits of one register. It
    // loads the next frame in the same cycle the last channel is taken.
    sfd_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_frame         (pop_frame),
        .i_stat          (q_stat),
        .o_pop           (pop),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_channel_index (o_channel_index),
        .o_channel_value (o_channel_value),
        .o_frame_flags   (o_frame_flags),
        .o_error_total   (o_error_total),
        .o_last_of_frame (o_last_of_frame)
    );

endmodule

### rtl/sfd_checker.sv
// ----------------------------------------------------------------------------
// sfd_checker: port-level checks for the SBUS frame decoder
// Watches the output channel sequencing and the stall behavior.
// ----------------------------------------------------------------------------
module sfd_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic [sfd_pkg::CHAN_W-1:0]    o_channel_index,
    input logic [sfd_pkg::CHAN_BITS-1:0] o_channel_value,
    input logic                          o_last_of_frame
);

    // Reset leaves no request pending.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("request pending after reset");

    // A stalled request holds its channel and value.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_channel_index)
                               && $stable(o_channel_value))
        else $error("stalled request changed");

    // The last marker sits on channel 15 and nowhere else.
    a_last_chan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last_of_frame == (o_channel_index == sfd_pkg::CHAN_LAST)))
        else $error("last marker on wrong channel");

    // Within a frame the channels follow one another without a gap.
    a_chan_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_last_of_frame |=>
            o_valid && (o_channel_index == $past(o_channel_index) + 1'b1))
        else $error("channel sequence broken");

    // A new frame starts at channel 0.
    a_frame_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && o_last_of_frame |=>
            !o_valid || (o_channel_index == sfd_pkg::CHAN_FIRST))
        else $error("frame does not start at channel 0");

endmodule

bind sbus_frame_decoder_unit sfd_checker u_sfd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_channel_index (o_channel_index),
    .o_channel_value (o_channel_value),
    .o_last_of_frame (o_last_of_frame)
);

### verif/tb_sbus_frame_decoder_unit.sv
// ----------------------------------------------------------------------------
// tb_sbus_frame_decoder_unit: self-checking testbench for the SBUS decoder
// Drives received bytes into the decoder and keeps its own model of the
// 25-byte window, the start and end byte checks and the saturating bad-end
// count. Every channel request that leaves the block is checked against the
// oldest predicted channel. Frames cover the data extremes, all four end
// bytes, lost sync, bad end bytes and random content.
// ----------------------------------------------------------------------------
module tb_sbus_frame_decoder_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int              FRAME_BYTES  = 25;
    localparam int              DATA_BYTES   = 22;
    localparam int              PAYLOAD_W    = DATA_BYTES * 8;
    localparam int              CHANNELS     = 16;
    localparam logic [7:0]      SYNC_BYTE    = 8'h0f;
    localparam logic [3:0][7:0] END_MARK     = {8'h34, 8'h24, 8'h14, 8'h04};
    localparam logic [7:0]      BAD_END      = 8'h05;
    localparam logic [15:0]     ERR_CEILING  = 16'hffff;
    localparam int              IDLE_PCT     = 32;
    localparam int              QUIET_LIMIT  = 5000;
    localparam int              DRAIN_CYCLES = 40;
    localparam int              REPORT_MAX   = 10;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_valid;
    logic                          o_stall;
    logic [7:0]                    i_rx_byte;
    logic                          o_valid;
    logic                          i_stall;
    logic [sfd_pkg::CHAN_W-1:0]    o_channel_index;
    logic [sfd_pkg::CHAN_BITS-1:0] o_channel_value;
    logic [7:0]                    o_frame_flags;
    logic [sfd_pkg::ERR_W-1:0]     o_error_total;
    logic                          o_last_of_frame;

    // One decoded channel as the block presents it.
    typedef struct packed {
        logic [sfd_pkg::CHAN_W-1:0]    index;
        logic [sfd_pkg::CHAN_BITS-1:0] value;
        logic [7:0]                    flags;
        logic [sfd_pkg::ERR_W-1:0]     errors;
        logic                          last;
    } t_channel;

    // Model state: the byte window, how many bytes it holds, the bad-end count.
    logic [7:0]  frame_bytes [FRAME_BYTES];
    int          bytes_in_window;
    logic [15:0] bad_end_total;
    t_channel    pending_channels [$];

    int failures;
    int quiet_cycles;
    bit in_gaps_on;
    bit out_stall_on;

    sbus_frame_decoder_unit DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_rx_byte       (i_rx_byte),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_channel_index (o_channel_index),
        .o_channel_value (o_channel_value),
        .o_frame_flags   (o_frame_flags),
        .o_error_total   (o_error_total),
        .o_last_of_frame (o_last_of_frame)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic bit is_end_mark(input logic [7:0] b);
        bit hit;
        hit = 1'b0;
        for (int k = 0; k < 4; k++) begin
            if (b == END_MARK[k]) hit = 1'b1;
        end
        return hit;
    endfunction

    function automatic void clear_window();
        for (int k = 0; k < FRAME_BYTES; k++) frame_bytes[k] = 8'h00;
        bytes_in_window = 0;
    endfunction

    // Takes one accepted byte into the window. A full window is examined once:
    // a wrong first byte or a wrong end byte drops the first byte, otherwise
    // the sixteen channels are queued and the window is emptied.
    function automatic void absorb_rx_byte(input logic [7:0] b);
        logic [PAYLOAD_W-1:0] payload;
        t_channel             rec;
        if (bytes_in_window < FRAME_BYTES) begin
            frame_bytes[bytes_in_window] = b;
            bytes_in_window++;
        end
        if (bytes_in_window < FRAME_BYTES) return;

        if (frame_bytes[0] != SYNC_BYTE || !is_end_mark(frame_bytes[FRAME_BYTES-1])) begin
            // Only a good start byte with a bad end byte counts as an error.
            if (frame_bytes[0] == SYNC_BYTE && bad_end_total != ERR_CEILING) begin
                bad_end_total++;
            end
            for (int k = 0; k < FRAME_BYTES - 1; k++) frame_bytes[k] = frame_bytes[k+1];
            frame_bytes[FRAME_BYTES-1] = 8'h00;
            bytes_in_window = FRAME_BYTES - 1;
            return;
        end

        // Bytes 1..22 form one little-endian bit stream of 16 x 11 bits.
        for (int k = 0; k < DATA_BYTES; k++) payload[8*k +: 8] = frame_bytes[k+1];
        for (int ch = 0; ch < CHANNELS; ch++) begin
            rec.index  = 4'(ch);
            rec.value  = payload[11*ch +: 11];
            rec.flags  = frame_bytes[23];
            rec.errors = bad_end_total;
            rec.last   = (ch == CHANNELS - 1);
            pending_channels.push_back(rec);
        end
        clear_window();
    endfunction

    function automatic logic [PAYLOAD_W-1:0] random_payload();
        logic [PAYLOAD_W-1:0] p;
        for (int k = 0; k < DATA_BYTES; k++) p[8*k +: 8] = 8'($urandom_range(255));
        return p;
    endfunction

    // Sends one byte request. It is called at a falling edge and returns at a
    // falling edge; valid stays high on return so that back-to-back requests
    // never lower and raise it in the same step.
    task automatic send_rx_byte(input logic [7:0] b);
        while (in_gaps_on && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (o_stall);
        absorb_rx_byte(b);
        @(negedge i_clk);
    endtask

    task automatic send_frame(input logic [PAYLOAD_W-1:0] payload,
                              input logic [7:0] flags, input logic [7:0] tail);
        send_rx_byte(SYNC_BYTE);
        for (int k = 0; k < DATA_BYTES; k++) send_rx_byte(payload[8*k +: 8]);
        send_rx_byte(flags);
        send_rx_byte(tail);
    endtask

    // All-ones and all-zero channel data with both flag extremes, sent as one
    // long stretch with no idling on either side.
    task automatic test_extreme_frames();
        in_gaps_on   = 1'b0;
        out_stall_on = 1'b0;
        send_frame({PAYLOAD_W{1'b1}}, 8'h00, END_MARK[0]);
        send_frame({PAYLOAD_W{1'b0}}, 8'hff, END_MARK[3]);
        in_gaps_on   = 1'b1;
        out_stall_on = 1'b1;
    endtask

    // Stray bytes ahead of a frame: the window has to slide until the start
    // byte lines up.
    task automatic test_bad_start();
        send_rx_byte(8'h00);
        send_rx_byte(8'hff);
        send_rx_byte(8'h0e);
        send_frame({DATA_BYTES{8'h55}}, 8'haa, END_MARK[1]);
    endtask

    // A frame with a wrong end byte bumps the error count, then a good frame
    // shows the new count.
    task automatic test_bad_end();
        send_frame(random_payload(), 8'($urandom_range(255)), BAD_END);
        send_frame(random_payload(), 8'($urandom_range(255)), END_MARK[2]);
    endtask

    // The output side stalls at random while stalling is enabled.
    always @(negedge i_clk) begin
        i_stall <= out_stall_on && ($urandom_range(99) < IDLE_PCT);
    end

    // Each channel request taken from the block is matched against the oldest
    // predicted channel.
    always @(posedge i_clk) begin
        t_channel seen;
        t_channel want;
        if (i_rst_n && o_valid && !i_stall) begin
            seen.index  = o_channel_index;
            seen.value  = o_channel_value;
            seen.flags  = o_frame_flags;
            seen.errors = o_error_total;
            seen.last   = o_last_of_frame;
            if (pending_channels.size() == 0) begin
                if (failures < REPORT_MAX) begin
                    $display("unexpected: idx %0d val %03h flags %02h err %0d last %0b",
                             seen.index, seen.value, seen.flags, seen.errors, seen.last);
                end
                failures++;
            end else begin
                want = pending_channels.pop_front();
                if (seen != want) begin
                    if (failures < REPORT_MAX) begin
                        $display("expected: idx %0d val %03h flags %02h err %0d last %0b",
                                 want.index, want.value, want.flags, want.errors,
                                 want.last);
                        $display("actual:   idx %0d val %03h flags %02h err %0d last %0b",
                                 seen.index, seen.value, seen.flags, seen.errors,
                                 seen.last);
                    end
                    failures++;
                end
            end
        end
    end

    // Ends the run when no request moves on either side for too long.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("** sbus_frame_decoder_unit: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_rx_byte      = 8'h00;
        i_stall        = 1'b0;
        in_gaps_on     = 1'b1;
        out_stall_on   = 1'b1;
        quiet_cycles   = 0;
        failures       = 0;
        bad_end_total  = 16'h0000;
        clear_window();

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_extreme_frames();
        test_bad_start();
        test_bad_end();
        i_valid <= 1'b0;

        // Let every predicted channel arrive, then watch a little longer for
        // anything the block should not have sent.
        while (pending_channels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (failures == 0) begin
            $display("** sbus_frame_decoder_unit: PASSED **");
        end else begin
            $display("** sbus_frame_decoder_unit: FAILED **");
        end
        $finish;
    end

endmodule
